[hdl/rtins_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtins_pkg;

   localparam int ROUTE_SLOTS_DEF = 16;

   localparam int ADDR_W     = 32;
   localparam int LEN_W      = 6;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

   localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] net_address;
      logic [LEN_W-1:0]  mask_length;
      logic [ADDR_W-1:0] gateway;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] network;
   } entry_type;

endpackage

`default_nettype wire

[hdl/route_table_insert_or_replace.sv]
// channel  ports                       direction  transfer
// req      start, busy, req_word       in         start high while busy low
// rsp      rsp_valid, rsp_word         out        one-cycle strobe, always taken
//
// a valid route holds busy high while the block reads the entry memory once per
// slot, compares each read with the word and writes the matching or first free
// slot, if any. busy falls as the response shows, the cycle after the write.
// a rejected prefix answers on the cycle after the word is taken.
// after reset the block sweeps the entry memory, one slot a cycle, clearing every
// slot with busy high before taking the first word.
// the receiver cannot stall: each response is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module route_table_insert_or_replace
   import rtins_pkg::*;
#(
   parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_valid,
   output rsp_type      rsp_word
);

   localparam int SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(ROUTE_SLOTS + 1);
   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(ROUTE_SLOTS);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(ROUTE_SLOTS - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ROUTE_SLOTS - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_WRITE = 2'd3;

   entry_type         entry_mem [ROUTE_SLOTS];
   logic [ADDR_W-1:0] hop_mem   [ROUTE_SLOTS];

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   req_type           item_ff, item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;
   entry_type         rd_data_ff;

   logic              accept;
   logic              bad_prefix;
   logic [ADDR_W-1:0] host_mask;
   logic              issue;
   logic              mem_we;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [SLOT_W-1:0] chosen;
   logic [SLOT_W+SLOT_OUT_W-1:0] chosen_ext;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign host_mask = {ADDR_W{1'b1}} >> req_word.mask_length;
   assign bad_prefix = (req_word.mask_length > MAX_LEN)
                    || ((req_word.net_address & host_mask) != '0);
   assign issue     = (state_ff == S_SCAN) && (idx_ff != SLOTS_CNT);

   assign chosen     = hit_ff ? hit_slot_ff : free_slot_ff;
   assign chosen_ext = {{SLOT_OUT_W{1'b0}}, chosen};

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = idx_ff[SLOT_W-1:0];
      wr_data = '{valid: 1'b0, length: '0, network: '0};
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_WRITE && (hit_ff || free_ff)) begin
         mem_we  = 1'b1;
         wr_addr = chosen;
         wr_data = '{valid: 1'b1, length: item_ff.mask_length,
                     network: item_ff.net_address};
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = issue;
      cmp_idx_in   = idx_ff[SLOT_W-1:0];
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      item_in      = item_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         S_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_CNT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in = req_word;
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               if (bad_prefix) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{status: ST_INVALID, slot: '0};
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (rd_data_ff.valid) begin
                  if (!hit_ff && rd_data_ff.network == item_ff.net_address
                      && rd_data_ff.length == item_ff.mask_length) begin
                     hit_in      = 1'b1;
                     hit_slot_in = cmp_idx_ff;
                  end
               end else if (!free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_SLOT) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (hit_ff) begin
               rsp_word_in = '{status: ST_REPLACED, slot: chosen_ext[SLOT_OUT_W-1:0]};
            end else if (free_ff) begin
               rsp_word_in = '{status: ST_INSERTED, slot: chosen_ext[SLOT_OUT_W-1:0]};
            end else begin
               rsp_word_in = '{status: ST_FULL, slot: '0};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmp_idx_ff   <= cmp_idx_in;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      item_ff      <= item_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_data;
         hop_mem[wr_addr]   <= item_ff.gateway;
      end
      rd_data_ff <= entry_mem[idx_ff[SLOT_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_write_then_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> rsp_valid)
      else $error("write cycle not followed by a response");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_WRITE) || ($past(accept) && $past(bad_prefix)))
      else $error("response without a finished scan or a rejected word");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == ST_FULL || rsp_word.status == ST_INVALID))
      |-> (rsp_word.slot == '0))
      else $error("nonzero slot on a full or rejected response");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_SCAN) |-> !mem_we)
      else $error("entry memory written outside clear or write cycle");

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import rtins_pkg::*;

   localparam int SLOTS        = ROUTE_SLOTS_DEF;
   localparam int NUM_RANDOM   = 1200;
   localparam int DRAIN_CYCLES = SLOTS + 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   bit      idle_off = 1'b0;
   int      routes_offered = 0;

   route_table_insert_or_replace #(
      .ROUTE_SLOTS(SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   function automatic logic [ADDR_W-1:0] net_mask_for(int unsigned len);
      if (len == 0) begin
         return '0;
      end
      if (len >= ADDR_W) begin
         return '1;
      end
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   class route_scoreboard;
      bit                entry_valid [SLOTS];
      logic [ADDR_W-1:0] entry_net   [SLOTS];
      logic [LEN_W-1:0]  entry_len   [SLOTS];
      logic [ADDR_W-1:0] entry_hop   [SLOTS];
      rsp_type           expected_replies[$];
      int                errors;
      int                replies_seen;
      int                status_count[4];

      function new();
         foreach (entry_valid[i]) begin
            entry_valid[i] = 1'b0;
         end
         foreach (status_count[i]) begin
            status_count[i] = 0;
         end
         errors = 0;
         replies_seen = 0;
      endfunction

      // work out the reply for one accepted route and update the shadow table
      function void install_route(req_type r);
         rsp_type want;
         int      hit;
         int      free_slot;
         int      chosen;
         want = '0;
         hit = -1;
         free_slot = -1;
         chosen = 0;
         if (r.mask_length > MAX_LEN ||
             (r.net_address & ~net_mask_for(r.mask_length)) != '0) begin
            want.status = ST_INVALID;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (entry_valid[i]) begin
                  if (hit < 0 && entry_net[i] == r.net_address &&
                      entry_len[i] == r.mask_length) begin
                     hit = i;
                  end
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               want.status = ST_REPLACED;
               chosen = hit;
            end else if (free_slot >= 0) begin
               want.status = ST_INSERTED;
               chosen = free_slot;
            end else begin
               want.status = ST_FULL;
            end
            if (want.status != ST_FULL) begin
               entry_valid[chosen] = 1'b1;
               entry_net[chosen]   = r.net_address;
               entry_len[chosen]   = r.mask_length;
               entry_hop[chosen]   = r.gateway;
               want.slot = SLOT_OUT_W'(chosen);
            end
         end
         status_count[want.status]++;
         expected_replies.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply status %0d slot %0d",
                                      got.status, got.slot));
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status) begin
            report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                      replies_seen, got.status, want.status));
         end
         if (got.slot !== want.slot) begin
            report_mismatch($sformatf("reply %0d slot %0d, want %0d",
                                      replies_seen, got.slot, want.slot));
         end
         replies_seen++;
      endtask
   endclass

   route_scoreboard sb = new();

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_reply(rsp_word);
      end
   end

   task automatic send_route(req_type r);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_word <= r;
      while (busy !== 1'b0) @(negedge clock);
      sb.install_route(r);
      routes_offered++;
   endtask

   task automatic send_fields(logic [ADDR_W-1:0] net, int len, logic [ADDR_W-1:0] hop);
      req_type r;
      r.net_address = net;
      r.mask_length = LEN_W'(len);
      r.gateway = hop;
      send_route(r);
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
   endtask

   function automatic req_type good_route();
      req_type r;
      int      len;
      len = ($urandom_range(0, 99) < 80) ? $urandom_range(20, 32) : $urandom_range(0, 32);
      r.mask_length = LEN_W'(len);
      r.net_address = $urandom & net_mask_for(len);
      r.gateway = $urandom;
      return r;
   endfunction

   function automatic req_type bad_route();
      req_type r;
      int      len;
      r.gateway = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         len = $urandom_range(MAX_LEN + 1, 63);
         r.net_address = $urandom;
      end else begin
         len = $urandom_range(0, ADDR_W - 1);
         r.net_address = $urandom | (32'h1 << $urandom_range(0, ADDR_W - 1 - len));
      end
      r.mask_length = LEN_W'(len);
      return r;
   endfunction

   initial begin
      req_type r;
      req_type route_pool[$];
      int      pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rejects: long lengths and host bits
      send_fields(32'h0A00_0000, 33, 32'h0A00_0001);
      send_fields(32'h0000_0000, 63, 32'hFFFF_FFFF);
      send_fields(32'h8000_0000, 0, 32'h0000_0001);
      send_fields(32'hFFFF_FFFF, 31, 32'h1234_5678);
      send_fields(32'hC0A8_0101, 24, 32'hC0A8_0101);
      send_fields(32'hC0A8_0100, 23, 32'hC0A8_0001);
      // inserts and replaces
      send_fields(32'h0000_0000, 0, 32'hFFFF_FFFF);
      send_fields(32'hFFFF_FFFF, 32, 32'h0000_0000);
      send_fields(32'hC0A8_0100, 24, 32'hC0A8_0101);
      send_fields(32'hC0A8_0100, 24, 32'hC0A8_01FE);
      send_fields(32'hC0A8_0000, 16, 32'hAAAA_AAAA);
      send_fields(32'h0000_0000, 0, 32'h5555_5555);
      send_fields(32'h8000_0000, 1, 32'h8000_0001);
      send_fields(32'hFFFF_FFFF, 32, 32'hDEAD_BEEF);
      send_fields(32'hFFFF_FFFE, 31, 32'h0F0F_0F0F);
      wait_for_replies();

      // replays of known routes, fresh routes until the table fills, and rejects
      for (int n = 0; n < NUM_RANDOM; n++) begin
         idle_off = ((n / 100) % 4) == 3;
         if (n % 200 == 199) begin
            wait_for_replies();
         end
         pick = $urandom_range(0, 99);
         if (pick < 45 && route_pool.size() != 0) begin
            r = route_pool[$urandom_range(0, route_pool.size() - 1)];
            r.gateway = $urandom;
         end else if (pick < 70) begin
            r = good_route();
            route_pool.push_back(r);
         end else begin
            r = bad_route();
         end
         send_route(r);
      end
      @(negedge clock);
      start <= 1'b0;

      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d routes offered, %0d replies checked", routes_offered, sb.replies_seen);
      $display("replaced %0d, inserted %0d, table full %0d, rejected %0d",
               sb.status_count[ST_REPLACED], sb.status_count[ST_INSERTED],
               sb.status_count[ST_FULL], sb.status_count[ST_INVALID]);
      if (sb.errors == 0) begin
         $display("route_table_insert_or_replace: match");
      end else begin
         $display("route_table_insert_or_replace: mismatch");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d replies outstanding", sb.expected_replies.size());
      $display("route_table_insert_or_replace: mismatch");
      $finish;
   end

endmodule

[route_table_insert_or_replace.f]
hdl/rtins_pkg.sv
hdl/route_table_insert_or_replace.sv
sim/tb.sv
